/* src/dsag_pkg.sv */
`default_nettype none

package dsag_pkg;

    // parameter defaults
    localparam int DEF_HISTORY_DEPTH    = 64;
    localparam int DEF_MAX_RECORD_BEATS = 8;
    localparam int DEF_PROB_BITS        = 16;

    // APB address width: eight 32-bit registers
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // register map, word index = paddr[4:2]
    typedef enum logic [2:0] {
        REG_RECORD_THR   = 3'd0,
        REG_BEAT_THR     = 3'd1,
        REG_ANY_OF_N     = 3'd2,
        REG_CONFIRM_WIN  = 3'd3,
        REG_CONFIRM_NEED = 3'd4,
        REG_HOLDOFF      = 3'd5,
        REG_MEAN_WIN     = 3'd6,
        REG_RECORD_BEATS = 3'd7
    } t_reg_idx;

    // reset values
    localparam logic [15:0] RST_RECORD_THR   = 16'd32768;
    localparam logic [15:0] RST_BEAT_THR     = 16'd9830;
    localparam logic        RST_ANY_OF_N     = 1'b1;
    localparam logic [6:0]  RST_CONFIRM_WIN  = 7'd5;
    localparam logic [6:0]  RST_CONFIRM_NEED = 7'd1;
    localparam logic [15:0] RST_HOLDOFF      = 16'd20;
    localparam logic [6:0]  RST_MEAN_WIN     = 7'd5;
    localparam logic [3:0]  RST_RECORD_BEATS = 4'd5;

    // configuration handed from the register file to the datapath
    typedef struct packed {
        logic [15:0] record_threshold;
        logic [15:0] beat_threshold;
        logic        any_of_n_mode;
        logic [6:0]  confirm_window;
        logic [6:0]  confirm_needed;
        logic [15:0] holdoff_beats;
        logic [6:0]  mean_window;
        logic [3:0]  record_beats;
    } t_cfg;

endpackage

`default_nettype wire

/* src/dsag_if.sv */
`default_nettype none

// input channel: one beat of model probabilities
interface dsag_in_if #(
    parameter int PROB_BITS = 16
);
    logic                 valid;
    logic                 ready;
    logic [PROB_BITS-1:0] beat_probability;
    logic [PROB_BITS-1:0] record_probability;

    modport source (output valid, beat_probability, record_probability, input ready);
    modport sink   (input valid, beat_probability, record_probability, output ready);
endinterface

// output channel: one gate decision per beat
interface dsag_out_if #(
    parameter int SUM_W = 22,
    parameter int CNT_W = 7
);
    logic             valid;
    logic             ready;
    logic [SUM_W-1:0] score_sum;
    logic [CNT_W-1:0] score_count;
    logic             record_valid;
    logic             gate_positive;
    logic             alarm;
    logic [31:0]      beat_number;
    logic [31:0]      alarm_total;

    modport source (output valid, score_sum, score_count, record_valid, gate_positive,
                    alarm, beat_number, alarm_total, input ready);
    modport sink   (input valid, score_sum, score_count, record_valid, gate_positive,
                    alarm, beat_number, alarm_total, output ready);
endinterface

`default_nettype wire

/* src/dsag_ram.sv */
`default_nettype none

// simple dual-port RAM, one write and one registered read per cycle
module dsag_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* src/dsag_regs.sv */
`default_nettype none

// APB register file
module dsag_regs
    import dsag_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output t_cfg                    o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // register writes, access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.record_threshold <= RST_RECORD_THR;
            r_cfg.beat_threshold   <= RST_BEAT_THR;
            r_cfg.any_of_n_mode    <= RST_ANY_OF_N;
            r_cfg.confirm_window   <= RST_CONFIRM_WIN;
            r_cfg.confirm_needed   <= RST_CONFIRM_NEED;
            r_cfg.holdoff_beats    <= RST_HOLDOFF;
            r_cfg.mean_window      <= RST_MEAN_WIN;
            r_cfg.record_beats     <= RST_RECORD_BEATS;
        end else if (w_wr) begin
            case (w_idx)
                REG_RECORD_THR:   r_cfg.record_threshold <= pwdata[15:0];
                REG_BEAT_THR:     r_cfg.beat_threshold   <= pwdata[15:0];
                REG_ANY_OF_N:     r_cfg.any_of_n_mode    <= pwdata[0];
                REG_CONFIRM_WIN:  r_cfg.confirm_window   <= pwdata[6:0];
                REG_CONFIRM_NEED: r_cfg.confirm_needed   <= pwdata[6:0];
                REG_HOLDOFF:      r_cfg.holdoff_beats    <= pwdata[15:0];
                REG_MEAN_WIN:     r_cfg.mean_window      <= pwdata[6:0];
                REG_RECORD_BEATS: r_cfg.record_beats     <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (w_idx)
            REG_RECORD_THR:   prdata = {16'd0, r_cfg.record_threshold};
            REG_BEAT_THR:     prdata = {16'd0, r_cfg.beat_threshold};
            REG_ANY_OF_N:     prdata = {31'd0, r_cfg.any_of_n_mode};
            REG_CONFIRM_WIN:  prdata = {25'd0, r_cfg.confirm_window};
            REG_CONFIRM_NEED: prdata = {25'd0, r_cfg.confirm_needed};
            REG_HOLDOFF:      prdata = {16'd0, r_cfg.holdoff_beats};
            REG_MEAN_WIN:     prdata = {25'd0, r_cfg.mean_window};
            REG_RECORD_BEATS: prdata = {28'd0, r_cfg.record_beats};
            default:          prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

/* src/dsag_core.sv */
`default_nettype none

// Datapath: input register, compute stage, result register.
// Window sums come from cumulative totals kept in RAM: the window value is
// the newest total minus the total n beats back, so no pass over the
// history is needed and a window change takes effect on the next beat.
module dsag_core
    import dsag_pkg::*;
#(
    parameter int HISTORY_DEPTH    = DEF_HISTORY_DEPTH,
    parameter int MAX_RECORD_BEATS = DEF_MAX_RECORD_BEATS,
    parameter int PROB_BITS        = DEF_PROB_BITS,
    localparam int AW    = $clog2(HISTORY_DEPTH),
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1),
    localparam int SUM_W = PROB_BITS + AW
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cfg                 i_cfg,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [PROB_BITS-1:0] i_beat_probability,
    input  wire logic [PROB_BITS-1:0] i_record_probability,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic      [SUM_W-1:0]     o_score_sum,
    output logic      [CNT_W-1:0]     o_score_count,
    output logic                      o_record_valid,
    output logic                      o_gate_positive,
    output logic                      o_alarm,
    output logic      [31:0]          o_beat_number,
    output logic      [31:0]          o_alarm_total
);

    localparam int RB_W  = $clog2(MAX_RECORD_BEATS + 1);
    localparam int PRODW = 16 + CNT_W;
    localparam int CMPW  = (PRODW > SUM_W) ? PRODW : SUM_W;
    localparam int TW    = (PROB_BITS > 16) ? PROB_BITS : 16;

    // where the subtrahend of a window difference comes from
    typedef enum logic [1:0] {
        SUB_MEM,
        SUB_LAST,
        SUB_ZERO
    } t_sub_sel;

    // input register
    logic                 r_in_valid;
    logic [PROB_BITS-1:0] r_pb;
    logic [PROB_BITS-1:0] r_pr;

    // history state
    logic [AW-1:0]    r_pos,     n_pos;
    logic [CNT_W-1:0] r_fill,    n_fill;
    logic [SUM_W-1:0] r_cum_s;
    logic [CNT_W-1:0] r_cum_p;
    logic [RB_W-1:0]  r_rec_fill;
    logic [15:0]      r_hold;
    logic [31:0]      r_beats;
    logic [31:0]      r_alarms;

    // window prep for the next beat, registered with the RAM read
    logic [CNT_W-1:0] r_n_s;
    t_sub_sel         r_sel_s;
    t_sub_sel         r_sel_p;
    logic [PRODW-1:0] r_prod;

    // result register
    logic             r_out_valid;
    logic [SUM_W-1:0] r_o_sum;
    logic [CNT_W-1:0] r_o_cnt;
    logic             r_o_rvalid;
    logic             r_o_pos;
    logic             r_o_alarm;
    logic [31:0]      r_o_beats;
    logic [31:0]      r_o_alarms;

    logic w_fire;

    // clamped configuration
    logic [CNT_W-1:0] w_mw, w_cw, w_cn;
    logic [RB_W-1:0]  w_rb;

    always_comb begin
        if (i_cfg.mean_window == '0) begin
            w_mw = CNT_W'(1);
        end else if (32'(i_cfg.mean_window) > HISTORY_DEPTH) begin
            w_mw = CNT_W'(HISTORY_DEPTH);
        end else begin
            w_mw = CNT_W'(i_cfg.mean_window);
        end
        if (i_cfg.confirm_window == '0) begin
            w_cw = CNT_W'(1);
        end else if (32'(i_cfg.confirm_window) > HISTORY_DEPTH) begin
            w_cw = CNT_W'(HISTORY_DEPTH);
        end else begin
            w_cw = CNT_W'(i_cfg.confirm_window);
        end
        if (i_cfg.any_of_n_mode || i_cfg.confirm_needed == '0) begin
            w_cn = CNT_W'(1);
        end else if (32'(i_cfg.confirm_needed) > 32'(w_cw)) begin
            w_cn = w_cw;
        end else begin
            w_cn = CNT_W'(i_cfg.confirm_needed);
        end
        if (i_cfg.record_beats == '0) begin
            w_rb = RB_W'(1);
        end else if (32'(i_cfg.record_beats) > MAX_RECORD_BEATS) begin
            w_rb = RB_W'(MAX_RECORD_BEATS);
        end else begin
            w_rb = RB_W'(i_cfg.record_beats);
        end
    end

    // handshake
    assign w_fire     = r_in_valid & (~r_out_valid | i_out_ready);
    assign o_in_ready = ~r_in_valid | w_fire;

    // state after the beat in flight, if it fires now
    always_comb begin
        n_pos  = r_pos;
        n_fill = r_fill;
        if (w_fire) begin
            n_pos = (32'(r_pos) == HISTORY_DEPTH - 1) ? '0 : r_pos + AW'(1);
            if (32'(r_fill) != HISTORY_DEPTH) begin
                n_fill = r_fill + CNT_W'(1);
            end
        end
    end

    // window lengths, read addresses and subtrahend source for the next beat
    logic [CNT_W-1:0] w_f1, w_n_s, w_n_p;
    logic [AW:0]      w_t_s, w_t_p;
    logic [AW-1:0]    w_ra_s, w_ra_p;
    t_sub_sel         w_sel_s, w_sel_p;

    always_comb begin
        w_f1  = (32'(n_fill) == HISTORY_DEPTH) ? n_fill : n_fill + CNT_W'(1);
        w_n_s = (w_f1 < w_mw) ? w_f1 : w_mw;
        w_n_p = (w_f1 < w_cw) ? w_f1 : w_cw;
        w_t_s = {1'b0, n_pos} + (AW+1)'(HISTORY_DEPTH) - (AW+1)'(w_n_s);
        w_t_p = {1'b0, n_pos} + (AW+1)'(HISTORY_DEPTH) - (AW+1)'(w_n_p);
        w_ra_s = (32'(w_t_s) >= HISTORY_DEPTH) ? AW'(w_t_s - (AW+1)'(HISTORY_DEPTH))
                                               : w_t_s[AW-1:0];
        w_ra_p = (32'(w_t_p) >= HISTORY_DEPTH) ? AW'(w_t_p - (AW+1)'(HISTORY_DEPTH))
                                               : w_t_p[AW-1:0];
        // one back is the entry written this cycle: take it from the register;
        // a window reaching back before the first beat subtracts nothing
        if (w_n_s == CNT_W'(1)) begin
            w_sel_s = SUB_LAST;
        end else if (w_n_s == w_f1 && 32'(n_fill) != HISTORY_DEPTH) begin
            w_sel_s = SUB_ZERO;
        end else begin
            w_sel_s = SUB_MEM;
        end
        if (w_n_p == CNT_W'(1)) begin
            w_sel_p = SUB_LAST;
        end else if (w_n_p == w_f1 && 32'(n_fill) != HISTORY_DEPTH) begin
            w_sel_p = SUB_ZERO;
        end else begin
            w_sel_p = SUB_MEM;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n_s   <= w_n_s;
        r_sel_s <= w_sel_s;
        r_sel_p <= w_sel_p;
        r_prod  <= PRODW'(i_cfg.beat_threshold) * PRODW'(w_n_s);
    end

    // compute cycle
    logic [SUM_W-1:0] w_rd_s, w_cum_s, w_sub_s, w_sum;
    logic [CNT_W-1:0] w_rd_p, w_cum_p, w_sub_p, w_cnt;
    logic [RB_W-1:0]  w_rec_fill;
    logic             w_rvalid, w_pos, w_alarm;
    logic [15:0]      w_hold;

    always_comb begin
        w_cum_s = r_cum_s + SUM_W'(r_pb);
        case (r_sel_s)
            SUB_MEM:  w_sub_s = w_rd_s;
            SUB_LAST: w_sub_s = r_cum_s;
            SUB_ZERO: w_sub_s = '0;
            default:  w_sub_s = '0;
        endcase
        w_sum = w_cum_s - w_sub_s;

        w_rec_fill = (r_rec_fill < w_rb) ? r_rec_fill + RB_W'(1) : r_rec_fill;
        w_rvalid   = (w_rec_fill >= w_rb);

        w_pos = w_rvalid
              && (TW'(r_pr) >= TW'(i_cfg.record_threshold))
              && (CMPW'(w_sum) >= CMPW'(r_prod));

        w_cum_p = r_cum_p + CNT_W'(w_pos);
        case (r_sel_p)
            SUB_MEM:  w_sub_p = w_rd_p;
            SUB_LAST: w_sub_p = r_cum_p;
            SUB_ZERO: w_sub_p = '0;
            default:  w_sub_p = '0;
        endcase
        w_cnt = w_cum_p - w_sub_p;

        // holdoff and alarm
        w_alarm = 1'b0;
        w_hold  = r_hold;
        if (r_hold != '0) begin
            w_hold = r_hold - 16'd1;
        end else if (w_cnt >= w_cn) begin
            w_alarm = 1'b1;
            w_hold  = i_cfg.holdoff_beats;
        end
    end

    // cumulative totals, indexed by write position
    dsag_ram #(
        .WIDTH (SUM_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_score_ram (
        .i_clk   (i_clk),
        .i_we    (w_fire),
        .i_waddr (r_pos),
        .i_wdata (w_cum_s),
        .i_raddr (w_ra_s),
        .o_rdata (w_rd_s)
    );

    dsag_ram #(
        .WIDTH (CNT_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (w_fire),
        .i_waddr (r_pos),
        .i_wdata (w_cum_p),
        .i_raddr (w_ra_p),
        .o_rdata (w_rd_p)
    );

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
            r_fill      <= '0;
            r_cum_s     <= '0;
            r_cum_p     <= '0;
            r_rec_fill  <= '0;
            r_hold      <= '0;
            r_beats     <= '0;
            r_alarms    <= '0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            r_pos  <= n_pos;
            r_fill <= n_fill;
            if (w_fire) begin
                r_cum_s    <= w_cum_s;
                r_cum_p    <= w_cum_p;
                r_rec_fill <= w_rec_fill;
                r_hold     <= w_hold;
                r_beats    <= r_beats + 32'd1;
                r_alarms   <= r_alarms + 32'(w_alarm);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_pb <= i_beat_probability;
            r_pr <= i_record_probability;
        end
        if (w_fire) begin
            r_o_sum    <= w_sum;
            r_o_cnt    <= r_n_s;
            r_o_rvalid <= w_rvalid;
            r_o_pos    <= w_pos;
            r_o_alarm  <= w_alarm;
            r_o_beats  <= r_beats + 32'd1;
            r_o_alarms <= r_alarms + 32'(w_alarm);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_score_sum     = r_o_sum;
    assign o_score_count   = r_o_cnt;
    assign o_record_valid  = r_o_rvalid;
    assign o_gate_positive = r_o_pos;
    assign o_alarm         = r_o_alarm;
    assign o_beat_number   = r_o_beats;
    assign o_alarm_total   = r_o_alarms;

endmodule

`default_nettype wire

/* src/dual_score_alarm_gate.sv */
`default_nettype none

// Channel   Dir  Handshake     Payload
// i_in      in   valid/ready   beat_probability, record_probability
// o_out     out  valid/ready   score_sum, score_count, record_valid, gate_positive,
//                              alarm, beat_number, alarm_total
// apb       in   psel/penable  record_threshold .. record_beats at paddr 4*i
//
// One beat per cycle sustained while o_out accepts results; a beat taken into the
// input register is computed from there and its result is loaded into the result
// register, which drives o_out. The rate is set by the one read and one write per
// cycle on each cumulative-total RAM. Reset is synchronous and active low; the RAMs
// need no clearing pass. A stalled result holds in its register while one more beat
// waits in the input register.
module dual_score_alarm_gate
    import dsag_pkg::*;
#(
    parameter int HISTORY_DEPTH    = DEF_HISTORY_DEPTH,
    parameter int MAX_RECORD_BEATS = DEF_MAX_RECORD_BEATS,
    parameter int PROB_BITS        = DEF_PROB_BITS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    dsag_in_if.sink                 i_in,
    dsag_out_if.source              o_out,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    t_cfg w_cfg;

    dsag_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    dsag_core #(
        .HISTORY_DEPTH    (HISTORY_DEPTH),
        .MAX_RECORD_BEATS (MAX_RECORD_BEATS),
        .PROB_BITS        (PROB_BITS)
    ) u_core (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg                (w_cfg),
        .i_in_valid           (i_in.valid),
        .o_in_ready           (i_in.ready),
        .i_beat_probability   (i_in.beat_probability),
        .i_record_probability (i_in.record_probability),
        .o_out_valid          (o_out.valid),
        .i_out_ready          (o_out.ready),
        .o_score_sum          (o_out.score_sum),
        .o_score_count        (o_out.score_count),
        .o_record_valid       (o_out.record_valid),
        .o_gate_positive      (o_out.gate_positive),
        .o_alarm              (o_out.alarm),
        .o_beat_number        (o_out.beat_number),
        .o_alarm_total        (o_out.alarm_total)
    );

endmodule

`default_nettype wire
